// ===== sv/tpbd_pkg.sv =====
package tpbd_pkg;

	localparam int unsigned WidthW = 8;
	localparam int unsigned AddrW  = 16;
	localparam int unsigned CountW = 16;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned HeaderBytes = 4;

	localparam logic [WidthW-1:0] ShortWidthRst = 8'd40;
	localparam logic [WidthW-1:0] LongWidthRst  = 8'd80;
	localparam logic [WidthW-1:0] ToleranceRst  = 8'd10;
	localparam logic [CountW-1:0] MinPilotRst   = 16'd500;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_SHORT_WIDTH = 2'd0,
		CFG_LONG_WIDTH  = 2'd1,
		CFG_TOLERANCE   = 2'd2,
		CFG_MIN_PILOT   = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_PILOT  = 3'd1,
		PH_SYNC   = 3'd2,
		PH_HEADER = 3'd3,
		PH_DATA   = 3'd4,
		PH_CHECK  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_CHECK  = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_BAD_PULSE = 2'd1,
		ERR_PAUSE     = 2'd2,
		ERR_ADDR      = 2'd3
	} err_t;

endpackage

// ===== sv/tpbd_pulse_if.sv =====
interface tpbd_pulse_if;
	import tpbd_pkg::*;

	logic              valid;
	logic              ready;
	logic [WidthW-1:0] pulse_width;
	logic              is_pause;

	modport source (output valid, pulse_width, is_pause, input ready);
	modport sink   (input valid, pulse_width, is_pause, output ready);
endinterface

// ===== sv/tpbd_result_if.sv =====
interface tpbd_result_if;
	import tpbd_pkg::*;

	logic              valid;
	logic              ready;
	logic [WidthW-1:0] byte_value;
	logic [1:0]        item_kind;
	logic [1:0]        error_code;
	logic [WidthW-1:0] sum_expected;
	logic              sum_match;
	logic              last;

	modport source (output valid, byte_value, item_kind, error_code, sum_expected,
		sum_match, last, input ready);
	modport sink   (input valid, byte_value, item_kind, error_code, sum_expected,
		sum_match, last, output ready);
endinterface

// ===== sv/tape_pulse_block_decoder.sv =====
// Tape pulse block decoder.
// pulse_in carries one tape pulse per beat (width and pause flag); result_out
// carries one decoded byte or error per beat. Only pulses that complete a
// byte, or that break the block, give a result beat; all others give none.
// Configuration is written through cfg_we/cfg_idx/cfg_data; the user must
// write it only while idle; the block does not enforce this. A pulse is
// registered at input, then classified and folded into the decoder state on
// the edge where it advances, which also loads result_out. Throughput: one
// pulse per cycle while result_out does not stall; the classifier and byte
// assembler are a single stage of compare, subtract and shift logic.
// Reset puts the decoder in pilot hunting, clears the counters, address and
// checksum registers, and loads the nominal widths, tolerance and minimum
// pilot length with their defaults.
// When result_out stalls, the held result stays put and the input stage keeps
// one pulse; pulse_in.ready then drops until the result beat is taken.
module tape_pulse_block_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tpbd_pkg::CfgIdxW-1:0]      cfg_idx,
	input  logic [tpbd_pkg::CfgDataW-1:0]     cfg_data,
	tpbd_pulse_if.sink                        pulse_in,
	tpbd_result_if.source                     result_out
);
	import tpbd_pkg::*;

	logic [WidthW-1:0] short_width_q, long_width_q, tolerance_q;
	logic [CountW-1:0] min_pilot_q;

	logic              valid_s1;
	logic [WidthW-1:0] width_s1;
	logic              pause_s1;
	logic              adv;

	phase_t            phase_q, phase_n;
	logic [CountW-1:0] pilot_cnt_q, pilot_cnt_n;
	logic [7:0]        shift_q, shift_n;
	logic [3:0]        bit_idx_q, bit_idx_n;
	logic              second_q, second_n;
	logic [1:0]        hdr_idx_q, hdr_idx_n;
	logic [AddrW-1:0]  start_q, start_n, end_q, end_n, left_q, left_n;
	logic [7:0]        sum_q, sum_n;

	logic              emit;
	logic [7:0]        r_byte, r_sum;
	kind_t             r_kind;
	err_t              r_err;
	logic              r_match, r_last;

	logic              is_short, is_long, bit_v, done, failed;
	err_t              fail_code;
	logic [WidthW:0]   w_ext;
	logic [7:0]        d_short, d_long, b;

	logic              out_valid_q;
	logic [7:0]        out_byte_q, out_sum_q;
	logic [1:0]        out_kind_q, out_err_q;
	logic              out_match_q, out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_width_q <= ShortWidthRst;
			long_width_q  <= LongWidthRst;
			tolerance_q   <= ToleranceRst;
			min_pilot_q   <= MinPilotRst;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_SHORT_WIDTH: short_width_q <= cfg_data[WidthW-1:0];
				CFG_LONG_WIDTH:  long_width_q  <= cfg_data[WidthW-1:0];
				CFG_TOLERANCE:   tolerance_q   <= cfg_data[WidthW-1:0];
				CFG_MIN_PILOT:   min_pilot_q   <= cfg_data[CountW-1:0];
				default:         min_pilot_q   <= min_pilot_q;
			endcase
		end
	end

	assign adv            = valid_s1 && (!out_valid_q || result_out.ready);
	assign pulse_in.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pulse_in.ready) begin
			valid_s1 <= pulse_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pulse_in.ready && pulse_in.valid) begin
			width_s1 <= pulse_in.pulse_width;
			pause_s1 <= pulse_in.is_pause;
		end
	end

	// strict window n - t < w < n + t, done as w + t > n and w < n + t
	assign w_ext    = {1'b0, width_s1};
	assign is_short = (w_ext + {1'b0, tolerance_q} > {1'b0, short_width_q}) &&
		(w_ext < {1'b0, short_width_q} + {1'b0, tolerance_q});
	assign is_long  = (w_ext + {1'b0, tolerance_q} > {1'b0, long_width_q}) &&
		(w_ext < {1'b0, long_width_q} + {1'b0, tolerance_q});
	assign d_short  = (width_s1 > short_width_q) ? width_s1 - short_width_q
		: short_width_q - width_s1;
	assign d_long   = (width_s1 > long_width_q) ? width_s1 - long_width_q
		: long_width_q - width_s1;

	always_comb begin
		phase_n     = phase_q;
		pilot_cnt_n = pilot_cnt_q;
		shift_n     = shift_q;
		bit_idx_n   = bit_idx_q;
		second_n    = second_q;
		hdr_idx_n   = hdr_idx_q;
		start_n     = start_q;
		end_n       = end_q;
		left_n      = left_q;
		sum_n       = sum_q;
		emit        = 1'b0;
		r_byte      = '0;
		r_kind      = KIND_HEADER;
		r_err       = ERR_NONE;
		r_sum       = '0;
		r_match     = 1'b0;
		r_last      = 1'b0;
		done        = 1'b0;
		failed      = 1'b0;
		fail_code   = ERR_NONE;
		bit_v       = 1'b0;
		b           = '0;
		case (phase_q)
			PH_HUNT: begin
				if (!pause_s1 && is_long) begin
					phase_n     = PH_PILOT;
					pilot_cnt_n = CountW'(1);
				end
			end
			PH_PILOT: begin
				if (!pause_s1 && is_long) begin
					if (pilot_cnt_q != '1) pilot_cnt_n = pilot_cnt_q + 1'b1;
				end else if (pilot_cnt_q > min_pilot_q && !pause_s1 && is_short) begin
					phase_n     = PH_SYNC;
					pilot_cnt_n = '0;
				end else begin
					phase_n     = PH_HUNT;
					pilot_cnt_n = '0;
				end
			end
			PH_SYNC: begin
				// second half of the sync bit is skipped unchecked
				phase_n   = PH_HEADER;
				hdr_idx_n = '0;
				shift_n   = '0;
				bit_idx_n = '0;
				second_n  = 1'b0;
				sum_n     = '0;
			end
			PH_HEADER, PH_DATA, PH_CHECK: begin
				if (second_q) begin
					second_n = 1'b0;
					done     = bit_idx_q[3];
				end else if (pause_s1) begin
					if (phase_q == PH_CHECK && bit_idx_q == 4'd7) begin
						shift_n   = {shift_q[6:0], 1'b0};
						bit_idx_n = 4'd8;
						done      = 1'b1;
					end else begin
						failed    = 1'b1;
						fail_code = ERR_PAUSE;
					end
				end else if (!is_short && !is_long) begin
					failed    = 1'b1;
					fail_code = ERR_BAD_PULSE;
				end else begin
					if (is_short && is_long) bit_v = !(d_long < d_short);
					else bit_v = is_short;
					shift_n   = {shift_q[6:0], bit_v};
					bit_idx_n = bit_idx_q + 1'b1;
					if (bit_v) second_n = 1'b1;
					else done = bit_idx_n[3];
				end

				if (done) begin
					b         = shift_n;
					shift_n   = '0;
					bit_idx_n = '0;
					second_n  = 1'b0;
					emit      = 1'b1;
					r_byte    = b;
					case (phase_q)
						PH_HEADER: begin
							r_kind = KIND_HEADER;
							r_sum  = sum_q;
							case (hdr_idx_q)
								2'd0:    start_n = {start_q[15:8], b};
								2'd1:    start_n = {b, start_q[7:0]};
								2'd2:    end_n   = {end_q[15:8], b};
								default: end_n   = {b, end_q[7:0]};
							endcase
							if (hdr_idx_q == 2'(HeaderBytes - 1)) begin
								hdr_idx_n = '0;
								if (end_n <= start_n) begin
									failed    = 1'b1;
									fail_code = ERR_ADDR;
								end else begin
									left_n  = end_n - start_n;
									phase_n = PH_DATA;
								end
							end else begin
								hdr_idx_n = hdr_idx_q + 1'b1;
							end
						end
						PH_DATA: begin
							sum_n  = sum_q + b + 8'd1;
							left_n = left_q - 1'b1;
							if (left_n == '0) phase_n = PH_CHECK;
							r_kind = KIND_DATA;
							r_sum  = sum_n;
						end
						default: begin
							r_kind      = KIND_CHECK;
							r_sum       = sum_q;
							r_match     = (b == sum_q);
							r_last      = 1'b1;
							phase_n     = PH_HUNT;
							pilot_cnt_n = '0;
							hdr_idx_n   = '0;
						end
					endcase
				end

				if (failed) begin
					emit        = 1'b1;
					r_byte      = '0;
					r_kind      = KIND_ERROR;
					r_err       = fail_code;
					r_sum       = '0;
					r_match     = 1'b0;
					r_last      = 1'b1;
					phase_n     = PH_HUNT;
					pilot_cnt_n = '0;
					shift_n     = '0;
					bit_idx_n   = '0;
					second_n    = 1'b0;
					hdr_idx_n   = '0;
				end
			end
			default: begin
				phase_n     = PH_HUNT;
				pilot_cnt_n = '0;
				shift_n     = '0;
				bit_idx_n   = '0;
				second_n    = 1'b0;
				hdr_idx_n   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			pilot_cnt_q <= '0;
			shift_q     <= '0;
			bit_idx_q   <= '0;
			second_q    <= 1'b0;
			hdr_idx_q   <= '0;
			start_q     <= '0;
			end_q       <= '0;
			left_q      <= '0;
			sum_q       <= '0;
		end else if (adv) begin
			phase_q     <= phase_n;
			pilot_cnt_q <= pilot_cnt_n;
			shift_q     <= shift_n;
			bit_idx_q   <= bit_idx_n;
			second_q    <= second_n;
			hdr_idx_q   <= hdr_idx_n;
			start_q     <= start_n;
			end_q       <= end_n;
			left_q      <= left_n;
			sum_q       <= sum_n;
		end
	end

	// result register, refilled on the same edge the old beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_byte_q  <= r_byte;
			out_kind_q  <= r_kind;
			out_err_q   <= r_err;
			out_sum_q   <= r_sum;
			out_match_q <= r_match;
			out_last_q  <= r_last;
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.byte_value   = out_byte_q;
	assign result_out.item_kind    = out_kind_q;
	assign result_out.error_code   = out_err_q;
	assign result_out.sum_expected = out_sum_q;
	assign result_out.sum_match    = out_match_q;
	assign result_out.last         = out_last_q;

endmodule

// ===== bench/tb.sv =====
module tb;
	import tpbd_pkg::*;

	typedef struct packed {
		logic [7:0] pw;
		logic       pause;
	} pulse_t;

	typedef struct {
		logic [7:0] value;
		kind_t      kind;
		err_t       err;
		logic [7:0] sum;
		logic       match;
		logic       last;
	} decoded_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_idx;
	logic [CfgDataW-1:0] cfg_data;

	tpbd_pulse_if  pin ();
	tpbd_result_if rout ();

	tape_pulse_block_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.pulse_in   (pin),
		.result_out (rout)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	pulse_t   pulse_q[$];
	decoded_t decoded_q[$];

	// register copies
	logic [7:0]  cfg_short, cfg_long, cfg_tol;
	logic [15:0] cfg_minp;

	// decoder state copy
	phase_t      dec_phase;
	logic [15:0] pilot_cnt;
	logic [7:0]  shift_reg;
	logic [3:0]  bit_cnt;
	bit          second_due;
	logic [1:0]  hdr_idx;
	logic [15:0] start_a, end_a, bytes_left;
	logic [7:0]  run_sum;

	bit steady;
	bit beat_taken;
	int send_wait, stall_left;
	int corrupt_permille;
	int queued, pulses_taken, results_seen, checkbytes_seen, errors_seen, reg_writes;
	int mismatches;

	function automatic bit near(logic [7:0] w, logic [7:0] nom);
		int x, n, t;
		x = int'(w);
		n = int'(nom);
		t = int'(cfg_tol);
		return x > n - t && x < n + t;
	endfunction

	function automatic int width_diff(logic [7:0] a, logic [7:0] b);
		return a > b ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	function automatic void go_hunt();
		dec_phase  = PH_HUNT;
		pilot_cnt  = '0;
		shift_reg  = '0;
		bit_cnt    = '0;
		second_due = 1'b0;
		hdr_idx    = '0;
	endfunction

	function automatic void push_result(logic [7:0] v, kind_t k, err_t e, logic [7:0] s,
		logic m, logic l);
		decoded_q.push_back('{value: v, kind: k, err: e, sum: s, match: m, last: l});
	endfunction

	function automatic void fail_with(err_t code);
		go_hunt();
		push_result(8'h00, KIND_ERROR, code, 8'h00, 1'b0, 1'b1);
	endfunction

	function automatic void finish_byte();
		logic [7:0] b, s;
		logic [1:0] h;
		b = shift_reg;
		shift_reg  = '0;
		bit_cnt    = '0;
		second_due = 1'b0;
		if (dec_phase == PH_HEADER) begin
			h = hdr_idx;
			case (h)
				2'd0: start_a[7:0] = b;
				2'd1: start_a[15:8] = b;
				2'd2: end_a[7:0] = b;
				default: end_a[15:8] = b;
			endcase
			if (h == HeaderBytes - 1) begin
				hdr_idx = '0;
				if (end_a <= start_a) begin
					fail_with(ERR_ADDR);
					return;
				end
				bytes_left = end_a - start_a;
				dec_phase = PH_DATA;
			end else begin
				hdr_idx = h + 2'd1;
			end
			push_result(b, KIND_HEADER, ERR_NONE, run_sum, 1'b0, 1'b0);
		end else if (dec_phase == PH_DATA) begin
			run_sum = run_sum + b + 8'd1;
			bytes_left = bytes_left - 16'd1;
			if (bytes_left == 0)
				dec_phase = PH_CHECK;
			push_result(b, KIND_DATA, ERR_NONE, run_sum, 1'b0, 1'b0);
		end else begin
			s = run_sum;
			go_hunt();
			push_result(b, KIND_CHECK, ERR_NONE, s, b == s, 1'b1);
		end
	endfunction

	function automatic void decode_pulse(logic [7:0] w, logic pause);
		bit s_ok, l_ok, bitv;
		s_ok = near(w, cfg_short);
		l_ok = near(w, cfg_long);
		case (dec_phase)
			PH_HUNT: begin
				if (!pause && l_ok) begin
					dec_phase = PH_PILOT;
					pilot_cnt = 16'd1;
				end
			end
			PH_PILOT: begin
				if (!pause && l_ok) begin
					if (pilot_cnt != 16'hFFFF)
						pilot_cnt = pilot_cnt + 16'd1;
				end else if (pilot_cnt > cfg_minp && !pause && s_ok) begin
					dec_phase = PH_SYNC;
					pilot_cnt = '0;
				end else begin
					go_hunt();
				end
			end
			PH_SYNC: begin
				// second half of the sync bit is swallowed whatever it is
				dec_phase  = PH_HEADER;
				hdr_idx    = '0;
				shift_reg  = '0;
				bit_cnt    = '0;
				second_due = 1'b0;
				run_sum    = '0;
			end
			default: begin
				if (second_due) begin
					second_due = 1'b0;
					if (bit_cnt >= 4'd8)
						finish_byte();
					return;
				end
				if (pause) begin
					// pause on the closing bit of the checkbyte reads as zero
					if (dec_phase == PH_CHECK && bit_cnt == 4'd7) begin
						shift_reg = {shift_reg[6:0], 1'b0};
						bit_cnt = 4'd8;
						finish_byte();
					end else begin
						fail_with(ERR_PAUSE);
					end
					return;
				end
				if (s_ok && l_ok)
					bitv = width_diff(w, cfg_long) < width_diff(w, cfg_short) ? 1'b0 : 1'b1;
				else if (s_ok)
					bitv = 1'b1;
				else if (l_ok)
					bitv = 1'b0;
				else begin
					fail_with(ERR_BAD_PULSE);
					return;
				end
				shift_reg = {shift_reg[6:0], bitv};
				bit_cnt = bit_cnt + 4'd1;
				if (bitv)
					second_due = 1'b1;
				else if (bit_cnt >= 4'd8)
					finish_byte();
			end
		endcase
	endfunction

	function automatic int idle_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// checks that a width decodes as intended under the current registers
	function automatic bit reads_ok(logic [7:0] w, bit want_long, bit sync_short);
		bit s_ok, l_ok;
		s_ok = near(w, cfg_short);
		l_ok = near(w, cfg_long);
		if (sync_short)
			return s_ok && !l_ok;
		if (want_long)
			return l_ok && (!s_ok || width_diff(w, cfg_long) < width_diff(w, cfg_short));
		return s_ok && (!l_ok || width_diff(w, cfg_long) >= width_diff(w, cfg_short));
	endfunction

	function automatic logic [7:0] pick_width(bit want_long, bit sync_short);
		logic [7:0] nom;
		int off, x;
		nom = want_long ? cfg_long : cfg_short;
		for (int tries = 0; tries < 6; tries++) begin
			off = 0;
			if (cfg_tol > 1)
				off = int'($urandom_range(0, 2 * cfg_tol - 2)) - (int'(cfg_tol) - 1);
			x = int'(nom) + off;
			if (x >= 0 && x <= 255 && reads_ok(x[7:0], want_long, sync_short))
				return x[7:0];
		end
		return nom;
	endfunction

	task automatic add_pulse(logic [7:0] w, logic p);
		if (int'($urandom_range(0, 999)) < corrupt_permille) begin
			w = 8'($urandom_range(0, 255));
			p = ($urandom_range(0, 5) == 0);
		end
		pulse_q.push_back('{pw: w, pause: p});
		queued++;
	endtask

	task automatic queue_bit(bit bitv, bit as_pause);
		int r;
		if (as_pause) begin
			add_pulse(8'($urandom_range(0, 255)), 1'b1);
		end else if (bitv) begin
			add_pulse(pick_width(1'b0, 1'b0), 1'b0);
			// second short goes unchecked
			r = $urandom_range(0, 99);
			if (r < 70)
				add_pulse(pick_width(1'b0, 1'b0), 1'b0);
			else if (r < 85)
				add_pulse(8'($urandom_range(0, 255)), 1'b0);
			else
				add_pulse(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			add_pulse(pick_width(1'b1, 1'b0), 1'b0);
		end
	endtask

	task automatic queue_byte(logic [7:0] b, bit pause_tail);
		for (int i = 7; i >= 0; i--)
			queue_bit(b[i], pause_tail && i == 0 && !b[0]);
	endtask

	task automatic queue_pilot_sync(int plen);
		// two pauses bring the decoder back to hunting from any state
		add_pulse(8'($urandom_range(0, 255)), 1'b1);
		add_pulse(8'($urandom_range(0, 255)), 1'b1);
		for (int i = 0; i < plen; i++)
			add_pulse(pick_width(1'b1, 1'b0), 1'b0);
		add_pulse(pick_width(1'b0, 1'b1), 1'b0);
		add_pulse(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	task automatic queue_block(int plen, logic [15:0] sa, logic [15:0] ea, bit good_chk,
		bit pause_tail);
		logic [7:0] data[$];
		logic [7:0] sum, chk;
		int n;
		queue_pilot_sync(plen);
		queue_byte(sa[7:0], 1'b0);
		queue_byte(sa[15:8], 1'b0);
		queue_byte(ea[7:0], 1'b0);
		queue_byte(ea[15:8], 1'b0);
		n = (ea > sa) ? int'(ea - sa) : 0;
		sum = '0;
		for (int i = 0; i < n; i++) begin
			data.push_back(8'($urandom_range(0, 255)));
			sum = sum + data[i] + 8'd1;
		end
		// an even checksum lets the closing pause stand for its zero bit
		if (pause_tail && good_chk && sum[0] && n > 0) begin
			data[n-1] = data[n-1] + 8'd1;
			sum = sum + 8'd1;
		end
		foreach (data[i])
			queue_byte(data[i], 1'b0);
		chk = good_chk ? sum : 8'($urandom_range(0, 255));
		if (n > 0)
			queue_byte(chk, pause_tail);
	endtask

	task automatic queue_noise(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 1))
				add_pulse(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			else
				add_pulse(pick_width(1'($urandom_range(0, 1)), 1'b0), 1'b0);
		end
	endtask

	task automatic queue_random_block();
		int plen, len, r;
		logic [15:0] sa, ea;
		r = $urandom_range(0, 99);
		if (r < 85)
			plen = int'(cfg_minp) + 1 + $urandom_range(0, 3);
		else
			plen = $urandom_range(1, int'(cfg_minp) + 1);
		r = $urandom_range(0, 99);
		if (r < 80)
			len = $urandom_range(1, 5);
		else if (r < 88)
			len = 0;
		else if (r < 94)
			len = -int'($urandom_range(1, 300));
		else
			len = $urandom_range(20, 40);
		if (len >= 0) begin
			sa = 16'($urandom_range(0, 65535 - len));
			ea = 16'(int'(sa) + len);
		end else begin
			sa = 16'($urandom_range(-len, 65535));
			ea = 16'(int'(sa) + len);
		end
		queue_block(plen, sa, ea, $urandom_range(0, 3) != 0, $urandom_range(0, 9) < 3);
	endtask

	task automatic drain();
		while (pulse_q.size() > 0 || pin.valid || decoded_q.size() > 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we   <= 1'b0;
		reg_writes++;
		case (idx)
			CFG_SHORT_WIDTH: cfg_short = val[7:0];
			CFG_LONG_WIDTH:  cfg_long  = val[7:0];
			CFG_TOLERANCE:   cfg_tol   = val[7:0];
			default:         cfg_minp  = val;
		endcase
	endtask

	task automatic set_regs(logic [7:0] sw, logic [7:0] lw, logic [7:0] tol, logic [15:0] mp);
		// upper bits of the narrow registers carry junk
		write_reg(CFG_SHORT_WIDTH, {8'($urandom_range(0, 255)), sw});
		write_reg(CFG_LONG_WIDTH, {8'($urandom_range(0, 255)), lw});
		write_reg(CFG_TOLERANCE, {8'($urandom_range(0, 255)), tol});
		write_reg(CFG_MIN_PILOT, mp);
	endtask

	// pulse side: accept at the rising edge, drive at the falling edge
	always @(posedge clk) begin
		if (arst_n && pin.valid && pin.ready) begin
			decode_pulse(pin.pulse_width, pin.is_pause);
			beat_taken = 1'b1;
			pulses_taken++;
		end
	end

	always @(negedge clk) begin
		pulse_t nxt;
		if (arst_n && (!pin.valid || beat_taken)) begin
			beat_taken = 1'b0;
			if (send_wait > 0) begin
				send_wait--;
				pin.valid <= 1'b0;
			end else if (pulse_q.size() > 0) begin
				nxt = pulse_q.pop_front();
				pin.pulse_width <= nxt.pw;
				pin.is_pause    <= nxt.pause;
				pin.valid       <= 1'b1;
				send_wait = idle_len();
			end else begin
				pin.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (steady) begin
				rout.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rout.ready <= 1'b0;
			end else begin
				rout.ready <= 1'b1;
				stall_left = idle_len();
			end
		end
	end

	always @(posedge clk) begin
		decoded_t e;
		if (arst_n && rout.valid && rout.ready) begin
			results_seen++;
			if (rout.item_kind == KIND_CHECK)
				checkbytes_seen++;
			if (rout.item_kind == KIND_ERROR)
				errors_seen++;
			if (decoded_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with nothing pending: val %h kind %0d err %0d",
						$time, rout.byte_value, rout.item_kind, rout.error_code);
			end else begin
				e = decoded_q.pop_front();
				if (rout.byte_value !== e.value || rout.item_kind !== e.kind ||
					rout.error_code !== e.err || rout.sum_expected !== e.sum ||
					rout.sum_match !== e.match || rout.last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: got val %h kind %0d err %0d sum %h match %b last %b,",
							" want val %h kind %0d err %0d sum %h match %b last %b"}, $time,
							rout.byte_value, rout.item_kind, rout.error_code,
							rout.sum_expected, rout.sum_match, rout.last,
							e.value, e.kind, e.err, e.sum, e.match, e.last);
				end
			end
		end
	end

	initial begin
		#60_000_000;
		$display("tape_pulse_block_decoder verification failed");
		$finish;
	end

	initial begin
		int target;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		pin.valid = 1'b0;
		pin.pulse_width = '0;
		pin.is_pause = 1'b0;
		rout.ready = 1'b0;
		steady = 1'b0;
		beat_taken = 1'b0;
		send_wait = 0;
		stall_left = 0;
		corrupt_permille = 0;
		cfg_short = ShortWidthRst;
		cfg_long  = LongWidthRst;
		cfg_tol   = ToleranceRst;
		cfg_minp  = MinPilotRst;
		go_hunt();
		start_a = '0;
		end_a = '0;
		bytes_left = '0;
		run_sum = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults: pilot just long enough
		queue_block(501, 16'h0000, 16'h0001, 1'b1, 1'b0);
		drain();

		// overlapping windows, shortest pilot
		set_regs(8'd40, 8'd60, 8'd15, 16'd0);
		queue_block(1, 16'hFFFE, 16'hFFFF, 1'b1, 1'b1);
		queue_pilot_sync(1);
		// closer wins, a tie reads short, a pause as second short is fine
		add_pulse(8'd49, 1'b0);
		add_pulse(8'd0, 1'b1);
		add_pulse(8'd50, 1'b0);
		add_pulse(8'd40, 1'b0);
		add_pulse(8'd51, 1'b0);
		repeat (5) add_pulse(8'd60, 1'b0);
		add_pulse(8'd100, 1'b0);
		queue_pilot_sync(2);
		add_pulse(8'd255, 1'b1);
		queue_block(3, 16'h1234, 16'h1234, 1'b1, 1'b0);
		queue_block(2, 16'h8000, 16'h7FFF, 1'b1, 1'b0);
		queue_block(2, 16'h0010, 16'h0013, 1'b0, 1'b0);
		drain();

		// zero tolerance: nothing ever qualifies
		set_regs(8'd40, 8'd80, 8'd0, 16'd3);
		queue_noise(20);
		add_pulse(8'd40, 1'b0);
		add_pulse(8'd80, 1'b0);
		drain();

		// widest windows, nominals at both ends
		set_regs(8'd0, 8'd255, 8'd255, 16'd2);
		queue_block(3, 16'h0042, 16'h0045, 1'b1, 1'b0);
		queue_noise(30);
		drain();
		set_regs(8'd255, 8'd0, 8'd255, 16'd2);
		queue_block(4, 16'h00F0, 16'h00F2, 1'b1, 1'b1);
		drain();

		// a pilot that can never be long enough
		steady = 1'b1;
		set_regs(8'd40, 8'd80, 8'd10, 16'hFFFF);
		queue_block(40, 16'h0300, 16'h0301, 1'b1, 1'b0);
		drain();
		steady = 1'b0;

		for (int phase_no = 0; phase_no < 7; phase_no++) begin
			int gap;
			logic [7:0] sw, lw;
			gap = $urandom_range(8, 70);
			sw = 8'($urandom_range(5, 250 - gap));
			lw = 8'(int'(sw) + gap);
			if ($urandom_range(0, 3) == 0)
				{sw, lw} = {lw, sw};
			set_regs(sw, lw, 8'($urandom_range(1, gap / 2 + 6)), 16'($urandom_range(0, 12)));
			corrupt_permille = $urandom_range(0, 20);
			steady = (phase_no == 3);
			target = queued + 40;
			while (queued < target) begin
				if ($urandom_range(0, 99) < 12)
					queue_noise($urandom_range(1, 15));
				else
					queue_random_block();
			end
			drain();
		end

		$display("run covered %0d pulses over %0d register writes", pulses_taken, reg_writes);
		$display("%0d result beats checked, %0d checkbytes, %0d errors, %0d mismatches",
			results_seen, checkbytes_seen, errors_seen, mismatches);
		if (mismatches == 0)
			$display("tape_pulse_block_decoder verification clean");
		else
			$display("tape_pulse_block_decoder verification failed");
		$finish;
	end
endmodule
